[rtl/imuca_pkg.sv]
// Shared types, command codes and constants for the IMU attitude filter.
// No dependencies; used by the controller, the datapath and the top level.
package imuca_pkg;

  localparam int CordicSteps = 23;
  localparam int CordicIdxW  = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLEND_WEIGHT   = 2'd0;
  localparam logic [1:0] REG_GYRO_STEP_GAIN = 2'd1;

  localparam logic [15:0] BLEND_WEIGHT_RESET   = 16'd62415;
  localparam logic [23:0] GYRO_STEP_GAIN_RESET = 24'd5115;

  // 90 degrees in Q.16.
  localparam logic signed [25:0] ANGLE_90 = 26'sd5898240;

  // floor(n / 34) == (n * TEMP_RECIP) >> TEMP_SHIFT for every n below 2^20.
  localparam logic [19:0] TEMP_RECIP  = 20'd986896;
  localparam int          TEMP_SHIFT  = 25;
  localparam logic signed [20:0] TEMP_OFFSET = 21'sd340017;
  localparam logic [14:0] TEMP_BIAS   = 15'd6347;

  // Operations issued to the shared multiplier, in slot order.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_GYRO_ROLL,
    OP_GYRO_PITCH,
    OP_GYRO_YAW,
    OP_BLEND_ROLL_LO,
    OP_BLEND_ROLL_HI,
    OP_FINISH_ROLL,
    OP_BLEND_PITCH_LO,
    OP_BLEND_PITCH_HI,
    OP_FINISH_PITCH
  } mul_op_t;

  typedef struct packed {
    logic                  load;
    logic                  cordic_init;
    logic                  cordic_pitch;
    logic                  cordic_step;
    logic [CordicIdxW-1:0] cordic_idx;
    logic                  cordic_save;
    mul_op_t               op;
    logic                  latch_out;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;
  } dp_status_t;

  // atan(2^-i) in degrees, Q.16, rounded.
  function automatic logic [21:0] atan_entry(input logic [CordicIdxW-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/imuca_ctrl.sv]
// Sequencing state machine for the IMU attitude filter.
// Depends on imuca_pkg; drives the datapath through dp_cmd_t.
module imuca_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  imuca_pkg::dp_status_t  status,
  output imuca_pkg::dp_cmd_t     cmd
);
  import imuca_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CINIT = 7'b0000010,
    ST_CSTEP = 7'b0000100,
    ST_CSAVE = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  localparam logic [CordicIdxW-1:0] LAST_STEP = CordicIdxW'(CordicSteps - 1);
  localparam logic [CordicIdxW-1:0] LAST_SLOT = 5'd8;

  state_t                state, state_next;
  logic                  pitch_pass, pitch_pass_next;
  logic [CordicIdxW-1:0] count, count_next;
  logic                  out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.cordic_pitch = pitch_pass;
    cmd.cordic_idx  = count;
    state_next      = state;
    pitch_pass_next = pitch_pass;
    count_next      = count;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load        = 1'b1;
          pitch_pass_next = 1'b0;
          state_next      = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.cordic_init = 1'b1;
        count_next      = '0;
        state_next      = ST_CSTEP;
      end
      ST_CSTEP: begin
        if (status.y_zero || count == LAST_STEP) begin
          cmd.cordic_step = !status.y_zero;
          state_next      = ST_CSAVE;
        end else begin
          cmd.cordic_step = 1'b1;
          count_next      = count + 1'b1;
        end
      end
      ST_CSAVE: begin
        cmd.cordic_save = 1'b1;
        if (!pitch_pass) begin
          pitch_pass_next = 1'b1;
          state_next      = ST_CINIT;
        end else begin
          count_next = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        case (count)
          5'd0:    cmd.op = OP_GYRO_ROLL;
          5'd1:    cmd.op = OP_GYRO_PITCH;
          5'd2:    cmd.op = OP_GYRO_YAW;
          5'd3:    cmd.op = OP_BLEND_ROLL_LO;
          5'd4:    cmd.op = OP_BLEND_ROLL_HI;
          5'd5:    cmd.op = OP_FINISH_ROLL;
          5'd6:    cmd.op = OP_BLEND_PITCH_LO;
          5'd7:    cmd.op = OP_BLEND_PITCH_HI;
          5'd8:    cmd.op = OP_FINISH_PITCH;
          default: cmd.op = OP_NONE;
        endcase
        if (count == LAST_SLOT) begin
          state_next = ST_DRAIN;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.latch_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && out_stall) || cmd.latch_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pitch_pass <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pitch_pass <= pitch_pass_next;
      count      <= count_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

[rtl/imuca_dp.sv]
// Datapath of the IMU attitude filter: CORDIC vectoring unit, shared
// multiplier with writeback, estimates, temperature path and output registers.
// Depends on imuca_pkg; commanded by imuca_ctrl.
module imuca_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  imuca_pkg::dp_cmd_t       cmd,
  output imuca_pkg::dp_status_t    status,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [23:0]              cfg_data,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_y,
  input  logic signed [15:0]       accel_z,
  input  logic signed [15:0]       gyro_x,
  input  logic signed [15:0]       gyro_y,
  input  logic signed [15:0]       gyro_z,
  input  logic signed [15:0]       temp_raw,
  output logic signed [23:0]       roll_angle,
  output logic signed [23:0]       pitch_angle,
  output logic signed [23:0]       yaw_angle,
  output logic signed [14:0]       temperature_centi
);
  import imuca_pkg::*;

  localparam logic signed [39:0] EST_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] EST_MIN = {1'b1, {39{1'b0}}};

  function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
    logic signed [39:0] r;
    if (v > 43'(EST_MAX)) begin
      r = EST_MAX;
    end else if (v < 43'(EST_MIN)) begin
      r = EST_MIN;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] angle_out(input logic signed [39:0] e);
    logic signed [40:0] v;
    logic signed [31:0] s;
    logic signed [23:0] r;
    v = 41'(e) + 41'sd256;
    s = v[40:9];
    if (s > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (s < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = s[23:0];
    end
    return r;
  endfunction

  logic [15:0]        blend_weight;
  logic [23:0]        gyro_step_gain;
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic [19:0]        temp_num;
  logic [39:0]        temp_prod;
  logic signed [39:0] cx, cy;
  logic signed [25:0] cz;
  logic signed [25:0] roll_acc, pitch_acc;
  logic signed [39:0] roll_est, pitch_est, yaw_est;
  logic signed [40:0] diff_roll, diff_pitch;
  logic signed [24:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [46:0] prod;
  mul_op_t            prod_op;
  logic signed [57:0] acc;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight   <= BLEND_WEIGHT_RESET;
      gyro_step_gain <= GYRO_STEP_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT:   blend_weight   <= cfg_data[15:0];
        REG_GYRO_STEP_GAIN: gyro_step_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture and temperature numerator (always positive, below 2^20).
  logic signed [20:0] tr_ext, temp_sum;
  assign tr_ext   = 21'(temp_raw);
  assign temp_sum = (tr_ext <<< 3) + (tr_ext <<< 1) + TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax       <= accel_x;
      ay       <= accel_y;
      az       <= accel_z;
      gx       <= gyro_x;
      gy       <= gyro_y;
      gz       <= gyro_z;
      temp_num <= temp_sum[19:0];
    end
    temp_prod <= temp_num * TEMP_RECIP;
  end

  // CORDIC vectoring with a quarter-turn pre-rotation for negative x.
  logic signed [15:0] y_in;
  logic signed [39:0] xs, ys, dx, dy;
  logic [21:0]        step_angle;
  assign y_in       = cmd.cordic_pitch ? ax : ay;
  assign xs         = {{8{az[15]}}, az, 16'b0};
  assign ys         = {{8{y_in[15]}}, y_in, 16'b0};
  assign dx         = cy >>> cmd.cordic_idx;
  assign dy         = cx >>> cmd.cordic_idx;
  assign step_angle = atan_entry(cmd.cordic_idx);
  assign status.y_zero = (cy == '0);

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      if (az[15]) begin
        if (!y_in[15]) begin
          cx <= ys;
          cy <= -xs;
          cz <= ANGLE_90;
        end else begin
          cx <= -ys;
          cy <= xs;
          cz <= -ANGLE_90;
        end
      end else begin
        cx <= xs;
        cy <= ys;
        cz <= '0;
      end
    end else if (cmd.cordic_step && !status.y_zero) begin
      if (!cy[39]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + $signed({4'b0, step_angle});
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - $signed({4'b0, step_angle});
      end
    end
    if (cmd.cordic_save) begin
      if (cmd.cordic_pitch) begin
        pitch_acc <= -cz;
      end else begin
        roll_acc <= cz;
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 25'({1'b0, gyro_step_gain});
    mul_b = '0;
    case (cmd.op)
      OP_GYRO_ROLL:  mul_b = 22'(gx);
      OP_GYRO_PITCH: mul_b = 22'(gy);
      OP_GYRO_YAW:   mul_b = 22'(gz);
      OP_BLEND_ROLL_LO: begin
        mul_a = 25'({1'b0, blend_weight});
        mul_b = {2'b0, diff_roll[19:0]};
      end
      OP_BLEND_ROLL_HI: begin
        mul_a = 25'({1'b0, blend_weight});
        mul_b = {diff_roll[40], diff_roll[40:20]};
      end
      OP_BLEND_PITCH_LO: begin
        mul_a = 25'({1'b0, blend_weight});
        mul_b = {2'b0, diff_pitch[19:0]};
      end
      OP_BLEND_PITCH_HI: begin
        mul_a = 25'({1'b0, blend_weight});
        mul_b = {diff_pitch[40], diff_pitch[40:20]};
      end
      default: ;
    endcase
  end

  // Writeback of the registered product, in the cycle after its issue.
  logic signed [46:0] gyro_round;
  logic signed [38:0] gyro_inc;
  logic signed [57:0] blend_round;
  logic signed [41:0] blend_inc;
  logic signed [39:0] gyro_base;
  logic signed [25:0] blend_base;
  logic signed [39:0] gyro_new, blend_new;

  assign gyro_round  = prod + 47'sd128;
  assign gyro_inc    = gyro_round[46:8];
  assign blend_round = acc + 58'sd32768;
  assign blend_inc   = blend_round[57:16];

  always_comb begin
    case (prod_op)
      OP_GYRO_PITCH: gyro_base = pitch_est;
      OP_GYRO_YAW:   gyro_base = yaw_est;
      default:       gyro_base = roll_est;
    endcase
  end
  assign blend_base = (prod_op == OP_FINISH_PITCH) ? pitch_acc : roll_acc;
  assign gyro_new   = sat40(43'(gyro_base) + 43'(gyro_inc));
  assign blend_new  = sat40(43'(blend_inc) + 43'(blend_base));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    diff_roll  <= 41'(roll_est) - 41'(roll_acc);
    diff_pitch <= 41'(pitch_est) - 41'(pitch_acc);
    case (prod_op)
      OP_BLEND_ROLL_LO, OP_BLEND_PITCH_LO: acc <= 58'(prod);
      OP_BLEND_ROLL_HI, OP_BLEND_PITCH_HI: acc <= acc + (58'(prod) <<< 20);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op   <= OP_NONE;
      roll_est  <= '0;
      pitch_est <= '0;
      yaw_est   <= '0;
    end else begin
      prod_op <= cmd.op;
      case (prod_op)
        OP_GYRO_ROLL:    roll_est  <= gyro_new;
        OP_GYRO_PITCH:   pitch_est <= gyro_new;
        OP_GYRO_YAW:     yaw_est   <= gyro_new;
        OP_FINISH_ROLL:  roll_est  <= blend_new;
        OP_FINISH_PITCH: pitch_est <= blend_new;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.latch_out) begin
      roll_angle        <= angle_out(roll_est);
      pitch_angle       <= angle_out(pitch_est);
      yaw_angle         <= angle_out(yaw_est);
      temperature_centi <= $signed(temp_prod[TEMP_SHIFT +: 15] - TEMP_BIAS);
    end
  end

endmodule

[rtl/imu_complementary_attitude.sv]
// Top level of the complementary-filter attitude estimator.
// Depends on imuca_pkg, imuca_ctrl and imuca_dp.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    accel_x..z, gyro_x..z, temp_raw
// output    out        out_valid / out_stall  roll, pitch, yaw angle, temp
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// From its transfer to its result entering the output register, an item passes
// through two CORDIC passes (pre-rotation, up to 23 micro-rotations, save), nine
// slots on the shared multiplier, a drain state and the output state. A CORDIC
// pass ends early once its y value is zero. The next transfer can happen in the
// cycle after the result enters the output register. in_stall is high from the
// input transfer until the result is in the output register; a stalled result
// holds and the next item waits behind it. Reset clears the three estimates and
// loads the register defaults.
module imu_complementary_attitude (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] temp_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] roll_angle,
  output logic signed [23:0] pitch_angle,
  output logic signed [23:0] yaw_angle,
  output logic signed [14:0] temperature_centi,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import imuca_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  imuca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  imuca_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .accel_x           (accel_x),
    .accel_y           (accel_y),
    .accel_z           (accel_z),
    .gyro_x            (gyro_x),
    .gyro_y            (gyro_y),
    .gyro_z            (gyro_z),
    .temp_raw          (temp_raw),
    .roll_angle        (roll_angle),
    .pitch_angle       (pitch_angle),
    .yaw_angle         (yaw_angle),
    .temperature_centi (temperature_centi)
  );

endmodule

[rtl/imuca_checks.sv]
// Port-level checks for the attitude estimator, bound to the top level.
// Depends only on the ports of imu_complementary_attitude.
module imuca_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] roll_angle,
  input logic signed [14:0] temperature_centi
);

  // Only one item is in flight: after a transfer the input side stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The temperature conversion stays within the sensor range.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(temperature_centi) >= -15'sd6000 &&
                   $signed(temperature_centi) <= 15'sd13300))
    else $error("temperature out of range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(roll_angle)))
    else $error("stalled result changed");

endmodule

bind imu_complementary_attitude imuca_checks u_checks (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .roll_angle        (roll_angle),
  .temperature_centi (temperature_centi)
);
